// ===== rtl/olsc_pkg.sv =====
// ---------------------------------------------------------------------------
// olsc_pkg: shared types and constants for the open-loop sine commutator
// Codes, state encodings, the Q1.15 quarter-wave sine table and its lookup.
// ---------------------------------------------------------------------------
package olsc_pkg;

    localparam int STEPS_PER_TURN_DEF = 96;
    localparam int ANGLE_BITS_DEF     = 12;

    localparam int DUTY_W      = 10;
    localparam int BAND_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [BAND_W-1:0] BAND_RESET = 8'd10;
    localparam logic [DUTY_W-1:0] FS_RESET   = 10'd999;

    // sine table geometry: 96 points per turn, quarter wave of 25 entries
    localparam int TABLE_POINTS = 96;
    localparam int QUARTER      = 24;
    localparam int TIDX_W       = 7;
    localparam int QSEL_W       = 5;
    localparam int TABLE_VAL_W  = 16;
    localparam int CPROD_W      = 32;
    localparam int U_W          = 33;
    localparam int PROD_W       = U_W + DUTY_W;

    localparam logic signed [CPROD_W-1:0] HALF_SQRT3_Q15 = 32'sd28378;

    localparam logic [TABLE_VAL_W-2:0] QUARTER_SINE [0:QUARTER] = '{
        15'd0,     15'd2143,  15'd4277,  15'd6393,  15'd8481,
        15'd10533, 15'd12539, 15'd14492, 15'd16384, 15'd18204,
        15'd19947, 15'd21605, 15'd23170, 15'd24636, 15'd25996,
        15'd27245, 15'd28377, 15'd29388, 15'd30273, 15'd31028,
        15'd31650, 15'd32137, 15'd32487, 15'd32697, 15'd32767
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAND_HALF_WIDTH  = 2'd0,
        CFG_PWM_FULL_SCALE   = 2'd1,
        CFG_DIRECTION_INVERT = 2'd2
    } cfg_index_t;

    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_TARGET = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } step_dir_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_FIN
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_DIV,
        DRV_LOOK,
        DRV_CPROD,
        DRV_SUM,
        DRV_MUL,
        DRV_DONE
    } drv_state_t;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
    } drv_result_t;

    // full-wave sine from the quarter table, idx in 0..95
    function automatic logic signed [TABLE_VAL_W-1:0] olsc_sine(
        input logic [TIDX_W-1:0] idx
    );
        logic [TIDX_W-1:0]      r;
        logic                   neg;
        logic [TABLE_VAL_W-1:0] mag;
        neg = 1'b0;
        if (idx < TIDX_W'(QUARTER)) begin
            r = idx;
        end else if (idx < TIDX_W'(2 * QUARTER)) begin
            r = TIDX_W'(2 * QUARTER) - idx;
        end else if (idx < TIDX_W'(3 * QUARTER)) begin
            r   = idx - TIDX_W'(2 * QUARTER);
            neg = 1'b1;
        end else begin
            r   = TIDX_W'(4 * QUARTER) - idx;
            neg = 1'b1;
        end
        mag = {1'b0, QUARTER_SINE[r[QSEL_W-1:0]]};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ===== rtl/olsc_drive.sv =====
// ---------------------------------------------------------------------------
// olsc_drive: phase-to-duty engine
// Serial phase-to-table division, sine/cosine lookup, inverse Clarke sums and
// a bit-serial scale by the PWM full-scale count.
// ---------------------------------------------------------------------------
module olsc_drive #(
    parameter int  STEPS_PER_TURN = olsc_pkg::STEPS_PER_TURN_DEF,
    localparam int PHASE_W        = $clog2(STEPS_PER_TURN)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [PHASE_W-1:0]          phase,
    input  logic [olsc_pkg::DUTY_W-1:0] full_scale,
    output olsc_pkg::drv_result_t       result
);
    import olsc_pkg::*;

    localparam int REM_W   = $clog2((2 ** TIDX_W) * STEPS_PER_TURN);
    localparam int CNT_W   = $clog2(DUTY_W + 1);
    localparam int SUM_W   = U_W + 1;
    localparam logic [REM_W-1:0] DIVISOR_TOP =
        REM_W'(STEPS_PER_TURN * (2 ** (TIDX_W - 1)));
    localparam logic [REM_W-1:0] HALF_STEP = REM_W'(STEPS_PER_TURN / 2);
    localparam logic signed [SUM_W-1:0] U_BASE = 34'sh1_0000_0000;

    drv_state_t state_reg, state_next;

    logic [CNT_W-1:0]              cnt_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [REM_W-1:0]              dsr_reg;
    logic [TIDX_W-1:0]             quo_reg;
    logic signed [TABLE_VAL_W-1:0] sin_reg;
    logic signed [TABLE_VAL_W-1:0] cos_reg;
    logic signed [CPROD_W-1:0]     cprod_reg;
    logic [U_W-1:0]                ua_reg, ub_reg, uc_reg;
    logic [DUTY_W-1:0]             fs_reg;
    logic [PROD_W-1:0]             acc_a_reg, acc_b_reg, acc_c_reg;

    logic [TIDX_W-1:0]         tidx, cidx;
    logic signed [CPROD_W-1:0] cos_ext;
    logic signed [SUM_W-1:0]   sin_ext, cprod_ext, ua_s, ub_s, uc_s;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DRV_IDLE:  if (start) state_next = DRV_DIV;
            DRV_DIV:   if (cnt_reg == CNT_W'(TIDX_W - 1)) state_next = DRV_LOOK;
            DRV_LOOK:  state_next = DRV_CPROD;
            DRV_CPROD: state_next = DRV_SUM;
            DRV_SUM:   state_next = DRV_MUL;
            DRV_MUL:   if (cnt_reg == CNT_W'(DUTY_W - 1)) state_next = DRV_DONE;
            DRV_DONE:  state_next = DRV_IDLE;
            default:   state_next = DRV_IDLE;
        endcase
        result.done   = (state_reg == DRV_DONE);
        result.duty_a = acc_a_reg[PROD_W-1 -: DUTY_W];
        result.duty_b = acc_b_reg[PROD_W-1 -: DUTY_W];
        result.duty_c = acc_c_reg[PROD_W-1 -: DUTY_W];
    end

    // table index, its quarter-turn shifted twin and the Clarke sums
    always_comb
    begin
        tidx = (quo_reg >= TIDX_W'(TABLE_POINTS)) ? '0 : quo_reg;
        cidx = (tidx >= TIDX_W'(TABLE_POINTS - QUARTER))
             ? tidx - TIDX_W'(TABLE_POINTS - QUARTER)
             : tidx + TIDX_W'(QUARTER);
        cos_ext   = {{(CPROD_W - TABLE_VAL_W){cos_reg[TABLE_VAL_W-1]}}, cos_reg};
        sin_ext   = {{(SUM_W - TABLE_VAL_W){sin_reg[TABLE_VAL_W-1]}}, sin_reg};
        cprod_ext = {{(SUM_W - CPROD_W){cprod_reg[CPROD_W-1]}}, cprod_reg};
        ua_s = U_BASE - (sin_ext <<< 16);
        ub_s = U_BASE + (sin_ext <<< 15) + cprod_ext;
        uc_s = U_BASE + (sin_ext <<< 15) - cprod_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= DRV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DRV_IDLE:
            begin
                rem_reg <= REM_W'(phase) * REM_W'(TABLE_POINTS) + HALF_STEP;
                dsr_reg <= DIVISOR_TOP;
                quo_reg <= '0;
            end
            DRV_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_reg >= dsr_reg) begin
                    rem_reg <= rem_reg - dsr_reg;
                    quo_reg <= {quo_reg[TIDX_W-2:0], 1'b1};
                end else begin
                    quo_reg <= {quo_reg[TIDX_W-2:0], 1'b0};
                end
                dsr_reg <= dsr_reg >> 1;
            end
            DRV_LOOK:
            begin
                sin_reg <= olsc_sine(tidx);
                cos_reg <= olsc_sine(cidx);
            end
            DRV_CPROD:
            begin
                cprod_reg <= cos_ext * HALF_SQRT3_Q15;
            end
            DRV_SUM:
            begin
                ua_reg    <= ua_s[U_W-1:0];
                ub_reg    <= ub_s[U_W-1:0];
                uc_reg    <= uc_s[U_W-1:0];
                fs_reg    <= full_scale;
                acc_a_reg <= '0;
                acc_b_reg <= '0;
                acc_c_reg <= '0;
            end
            DRV_MUL:
            begin
                // MSB-first shift and add over the full-scale bits
                acc_a_reg <= {acc_a_reg[PROD_W-2:0], 1'b0}
                           + (fs_reg[DUTY_W-1] ? PROD_W'(ua_reg) : '0);
                acc_b_reg <= {acc_b_reg[PROD_W-2:0], 1'b0}
                           + (fs_reg[DUTY_W-1] ? PROD_W'(ub_reg) : '0);
                acc_c_reg <= {acc_c_reg[PROD_W-2:0], 1'b0}
                           + (fs_reg[DUTY_W-1] ? PROD_W'(uc_reg) : '0);
                fs_reg    <= {fs_reg[DUTY_W-2:0], 1'b0};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/open_loop_sine_commutator.sv =====
// ---------------------------------------------------------------------------
// open_loop_sine_commutator: open-loop sinusoidal drive with dead-band stop
// Steps an electrical phase towards a target angle and emits three duties.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat: a tick
//   with the sensor angle, or a new target. Every request yields exactly one
//   result beat on the output channel (out_valid/out_ready): three phase
//   duties, the in-band flag and whether this beat carries fresh duties.
//   Config channel (cfg_valid/cfg_ready) is always ready; write it only while
//   the block is idle.
//   A tick that steps the phase runs, after acceptance, through the serial
//   divide mapping phase to the 96-point table, the lookup and Clarke sums,
//   and the bit-serial multiply by pwm_full_scale before its result shows.
//   Any other request skips the drive and goes straight to the finish state.
//   One request is in work at a time, so a new one is taken only once the
//   previous one has left the finish state.
//   The result sits in an output register: a stalled receiver holds it, and
//   the next request is still accepted and worked on; it then waits in the
//   finish state until the output register frees up.
//   Reset clears target, angle, phase, held duties and disarms the block;
//   config returns to band 10, full scale 999, no inversion.
// ---------------------------------------------------------------------------
module open_loop_sine_commutator #(
    parameter int  STEPS_PER_TURN = olsc_pkg::STEPS_PER_TURN_DEF,
    parameter int  ANGLE_BITS     = olsc_pkg::ANGLE_BITS_DEF,
    localparam int PHASE_W        = $clog2(STEPS_PER_TURN)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [ANGLE_BITS-1:0]           sensor_angle,
    input  logic [ANGLE_BITS-1:0]           target_angle,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [olsc_pkg::DUTY_W-1:0]     duty_a,
    output logic [olsc_pkg::DUTY_W-1:0]     duty_b,
    output logic [olsc_pkg::DUTY_W-1:0]     duty_c,
    output logic                            in_band,
    output logic                            drive_updated,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [olsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [olsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import olsc_pkg::*;

    // one spare bit so band edges compare without wrap
    localparam int CMP_W = ANGLE_BITS + 1;

    ctrl_state_t state_reg, state_next;

    // config registers
    logic [BAND_W-1:0] band_reg;
    logic [DUTY_W-1:0] fs_reg;
    logic              inv_reg;

    // control state
    logic [ANGLE_BITS-1:0] held_target_reg;
    logic [ANGLE_BITS-1:0] last_angle_reg;
    logic                  armed_reg;
    step_dir_t             step_dir_reg;
    logic [PHASE_W-1:0]    phase_reg;
    logic [DUTY_W-1:0]     held_a_reg, held_b_reg, held_c_reg;
    logic                  out_valid_reg;

    // per-request flags and output payload
    logic              inside_reg, updated_reg;
    logic [DUTY_W-1:0] out_a_reg, out_b_reg, out_c_reg;
    logic              out_band_reg, out_upd_reg;

    logic                  accept, load_out, drv_start;
    logic                  is_target, band_hit, ahead, do_step;
    logic [ANGLE_BITS-1:0] cmp_angle, cmp_target;
    logic [CMP_W-1:0]      a_ext, t_ext, b_ext;
    logic [PHASE_W-1:0]    phase_fwd, phase_bwd;
    drv_result_t           drv_res;

    // dead band check and step decision on the request in front
    always_comb
    begin
        is_target  = (req_t'(req_type) == REQ_TARGET);
        cmp_angle  = is_target ? last_angle_reg : sensor_angle;
        cmp_target = is_target ? target_angle : held_target_reg;
        a_ext      = {1'b0, cmp_angle};
        t_ext      = {1'b0, cmp_target};
        b_ext      = CMP_W'(band_reg);
        band_hit   = (a_ext + b_ext >= t_ext) && (a_ext <= t_ext + b_ext);
        ahead      = (target_angle > last_angle_reg);
        do_step    = !is_target && armed_reg && !band_hit;
        phase_fwd  = (phase_reg == PHASE_W'(STEPS_PER_TURN - 1)) ? '0 : phase_reg + 1'b1;
        phase_bwd  = (phase_reg == '0) ? PHASE_W'(STEPS_PER_TURN - 1) : phase_reg - 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        accept     = in_valid && in_ready;
        drv_start  = (state_reg == ST_LAUNCH);
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) state_next = do_step ? ST_LAUNCH : ST_FIN;
            end
            ST_LAUNCH:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (drv_res.done) state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    olsc_drive #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (drv_start),
        .phase      (phase_reg),
        .full_scale (fs_reg),
        .result     (drv_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            band_reg        <= BAND_RESET;
            fs_reg          <= FS_RESET;
            inv_reg         <= 1'b0;
            held_target_reg <= '0;
            last_angle_reg  <= '0;
            armed_reg       <= 1'b0;
            step_dir_reg    <= DIR_NONE;
            phase_reg       <= '0;
            held_a_reg      <= '0;
            held_b_reg      <= '0;
            held_c_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                case (cfg_index_t'(cfg_index))
                    CFG_BAND_HALF_WIDTH:  band_reg <= cfg_data[BAND_W-1:0];
                    CFG_PWM_FULL_SCALE:   fs_reg   <= cfg_data[DUTY_W-1:0];
                    CFG_DIRECTION_INVERT: inv_reg  <= cfg_data[0];
                    default:              ;
                endcase
            end

            if (accept) begin
                if (is_target) begin
                    held_target_reg <= target_angle;
                    armed_reg       <= 1'b1;
                    // equal angles count as not ahead
                    step_dir_reg    <= (ahead ^ inv_reg) ? DIR_FWD : DIR_BWD;
                end else begin
                    last_angle_reg <= sensor_angle;
                    if (do_step) begin
                        case (step_dir_reg)
                            DIR_FWD: phase_reg <= phase_fwd;
                            DIR_BWD: phase_reg <= phase_bwd;
                            default: ;
                        endcase
                    end
                end
            end

            if (drv_res.done) begin
                held_a_reg <= drv_res.duty_a;
                held_b_reg <= drv_res.duty_b;
                held_c_reg <= drv_res.duty_c;
            end

            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            inside_reg  <= band_hit;
            updated_reg <= do_step;
        end
        if (load_out) begin
            out_a_reg    <= held_a_reg;
            out_b_reg    <= held_b_reg;
            out_c_reg    <= held_c_reg;
            out_band_reg <= inside_reg;
            out_upd_reg  <= updated_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign duty_a        = out_a_reg;
    assign duty_b        = out_b_reg;
    assign duty_c        = out_c_reg;
    assign in_band       = out_band_reg;
    assign drive_updated = out_upd_reg;

endmodule

// ===== rtl/olsc_port_check.sv =====
// ---------------------------------------------------------------------------
// olsc_port_check: port-level checks for the open-loop sine commutator
// Watches the request and result channels; bound to the top level.
// ---------------------------------------------------------------------------
module olsc_port_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [olsc_pkg::DUTY_W-1:0] duty_a,
    input logic [olsc_pkg::DUTY_W-1:0] duty_b,
    input logic [olsc_pkg::DUTY_W-1:0] duty_c,
    input logic                        in_band,
    input logic                        drive_updated
);

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in work");

    // a phase step only happens outside the dead band
    a_step_outside_band: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(drive_updated && in_band))
        else $error("drive updated inside dead band");

    // a result appears only after a request left the idle state
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat without request in work");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty_a) && $stable(duty_b)
            && $stable(duty_c) && $stable(in_band) && $stable(drive_updated))
        else $error("stalled result beat changed");

endmodule

bind open_loop_sine_commutator olsc_port_check u_port_check (.*);
